// ===== rtl/cghma_pkg.sv =====
// ---------------------------------------------------------------------------
// cghma_pkg: shared types and constants for the greedy max-heap assigner
// Field widths, command codes, memory select codes and sift return codes.
// ---------------------------------------------------------------------------
package cghma_pkg;

  localparam int CMD_W  = 2;
  localparam int WGT_W  = 20;
  localparam int VAL_W  = 20;
  localparam int CAP_W  = 27;
  localparam int TOT_W  = 30;
  localparam int KEY_W  = WGT_W + VAL_W;

  localparam logic [CMD_W-1:0] CMD_LOAD_ITEM = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SLOT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN       = 2'd2;

  typedef enum logic [1:0] {
    SEL_ITEM = 2'd0,
    SEL_SLOT = 2'd1,
    SEL_HEAP = 2'd2
  } mem_sel_t;

  typedef enum logic [1:0] {
    RET_BLD = 2'd0,
    RET_EXT = 2'd1,
    RET_POP = 2'd2
  } sift_ret_t;

endpackage

// ===== rtl/cghma_ram.sv =====
// ---------------------------------------------------------------------------
// cghma_ram: one write port, two registered read ports
// Plain synchronous memory with registered read data.
// ---------------------------------------------------------------------------
module cghma_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 40
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DW-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [DW-1:0]                             rdata_a,
  output logic [DW-1:0]                             rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/capacity_greedy_max_heap_assign_core.sv =====
// ---------------------------------------------------------------------------
// capacity_greedy_max_heap_assign_core: greedy item-to-slot assignment
// Loads items and slot capacities into memory, then on a run command sorts
// both sets in place with heapsort and sweeps the slots from the smallest
// capacity up, feeding a max-heap of item values and taking its top at most
// once per slot. Emits the saturated total and the overflow flag.
// ---------------------------------------------------------------------------
//
//  channel  | direction | transaction
//  ---------+-----------+------------------------------------------------
//  in_*     | input     | command + item weight/value or slot capacity
//  out_*    | output    | total value and load-dropped flag (one per run)
//
//  Loads are accepted back to back.
//  A run sorts each set with heapsort, then pushes and pops a heap;
//  every sift step is a read then a compare/write over the memory of
//  that set, which has one write port and two read ports.
//  Reset clears the counts and flags only; the memories are never cleared.
//  A result waits in the output register; loads keep being accepted while
//  it waits, a run only once the register is free.
// ---------------------------------------------------------------------------
module capacity_greedy_max_heap_assign_core #(
  parameter int MAX_ITEMS = 1024,
  parameter int MAX_SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cghma_pkg::CMD_W-1:0] in_command,
  input  logic [cghma_pkg::WGT_W-1:0] in_item_weight,
  input  logic [cghma_pkg::VAL_W-1:0] in_item_value,
  input  logic [cghma_pkg::CAP_W-1:0] in_slot_capacity,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cghma_pkg::TOT_W-1:0] out_total_value,
  output logic                        out_load_dropped
);
  import cghma_pkg::*;

  localparam int MAXN = (MAX_ITEMS > MAX_SLOTS) ? MAX_ITEMS : MAX_SLOTS;
  localparam int CW   = $clog2(MAXN + 1);
  localparam int XW   = CW + 1;
  localparam int IAW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int SAW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  typedef enum logic [17:0] {
    ST_IDLE   = 18'h00001,
    ST_SORT   = 18'h00002,
    ST_BLD_RD = 18'h00004,
    ST_BLD_GO = 18'h00008,
    ST_EXT_RD = 18'h00010,
    ST_EXT_GO = 18'h00020,
    ST_SIFT_RD= 18'h00040,
    ST_SIFT_EV= 18'h00080,
    ST_RET    = 18'h00100,
    ST_M_SLOT = 18'h00200,
    ST_M_CAP  = 18'h00400,
    ST_M_ITEM = 18'h00800,
    ST_M_CHK  = 18'h01000,
    ST_UP_RD  = 18'h02000,
    ST_UP_EV  = 18'h04000,
    ST_M_POP  = 18'h08000,
    ST_POP_GO = 18'h10000,
    ST_OUT    = 18'h20000
  } state_t;

  state_t             state_r, state_nxt;
  mem_sel_t           sel_r, sel_nxt;
  sift_ret_t          ret_r, ret_nxt;
  logic [CW-1:0]      ni_r, ni_nxt, ns_r, ns_nxt, hs_r, hs_nxt;
  logic [CW-1:0]      j_r, j_nxt, lim_r, lim_nxt, hole_r, hole_nxt;
  logic [CW-1:0]      s_r, s_nxt, idx_r, idx_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [KEY_W-1:0]   v_r, v_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic               drop_r, drop_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TOT_W-1:0]   out_total_r, out_total_nxt;
  logic               out_drop_r, out_drop_nxt;

  // memory ports
  logic               mem_we;
  mem_sel_t           mem_wsel;
  logic [XW-1:0]      waddr, raddr_a, raddr_b;
  logic [KEY_W-1:0]   wdata;
  logic [KEY_W-1:0]   item_rd_a, item_rd_b;
  logic [CAP_W-1:0]   slot_rd_a, slot_rd_b;
  logic [VAL_W-1:0]   heap_rd_a, heap_rd_b;
  logic [KEY_W-1:0]   key_a, key_b;

  // sift helpers
  logic [XW-1:0]      lchild, rchild;
  logic               l_ok, r_ok, take;
  logic [KEY_W-1:0]   big_key;
  logic [XW-1:0]      big_idx;
  logic [CW-1:0]      n_sort, parent;
  logic [TOT_W:0]     sum;
  logic               in_fire;

  cghma_ram #(.DEPTH(MAX_ITEMS), .DW(KEY_W)) u_item_ram (
    .clk(clk), .we(mem_we && (mem_wsel == SEL_ITEM)), .waddr(waddr[IAW-1:0]),
    .wdata(wdata), .raddr_a(raddr_a[IAW-1:0]), .raddr_b(raddr_b[IAW-1:0]),
    .rdata_a(item_rd_a), .rdata_b(item_rd_b)
  );

  cghma_ram #(.DEPTH(MAX_SLOTS), .DW(CAP_W)) u_slot_ram (
    .clk(clk), .we(mem_we && (mem_wsel == SEL_SLOT)), .waddr(waddr[SAW-1:0]),
    .wdata(wdata[CAP_W-1:0]), .raddr_a(raddr_a[SAW-1:0]), .raddr_b(raddr_b[SAW-1:0]),
    .rdata_a(slot_rd_a), .rdata_b(slot_rd_b)
  );

  cghma_ram #(.DEPTH(MAX_ITEMS), .DW(VAL_W)) u_heap_ram (
    .clk(clk), .we(mem_we && (mem_wsel == SEL_HEAP)), .waddr(waddr[IAW-1:0]),
    .wdata(wdata[VAL_W-1:0]), .raddr_a(raddr_a[IAW-1:0]), .raddr_b(raddr_b[IAW-1:0]),
    .rdata_a(heap_rd_a), .rdata_b(heap_rd_b)
  );

  // Route the selected set's read data as a zero-extended key.
  always_comb begin
    case (sel_r)
      SEL_ITEM: begin
        key_a = item_rd_a;
        key_b = item_rd_b;
      end
      SEL_SLOT: begin
        key_a = KEY_W'(slot_rd_a);
        key_b = KEY_W'(slot_rd_b);
      end
      default: begin
        key_a = KEY_W'(heap_rd_a);
        key_b = KEY_W'(heap_rd_b);
      end
    endcase
  end

  // A run is held off while an earlier total still sits in the output register.
  assign in_ready = (state_r == ST_IDLE) && !((in_command == CMD_RUN) && out_valid_r);
  assign in_fire  = in_valid && in_ready;

  assign n_sort = (sel_r == SEL_ITEM) ? ni_r : ns_r;
  assign lchild = {hole_r, 1'b1};
  assign rchild = {hole_r, 1'b0} + XW'(2);
  assign parent = (hole_r - CW'(1)) >> 1;
  assign sum    = {1'b0, total_r} + (TOT_W + 1)'(heap_rd_a);

  // Pick the larger child; move it up into the hole if it beats the carried key.
  always_comb begin
    l_ok    = lchild < XW'(lim_r);
    r_ok    = rchild < XW'(lim_r);
    take    = 1'b0;
    big_key = v_r;
    big_idx = lchild;
    if (l_ok && (key_a > big_key)) begin
      take    = 1'b1;
      big_key = key_a;
    end
    if (r_ok && (key_b > big_key)) begin
      take    = 1'b1;
      big_key = key_b;
      big_idx = rchild;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    ret_nxt       = ret_r;
    ni_nxt        = ni_r;
    ns_nxt        = ns_r;
    hs_nxt        = hs_r;
    j_nxt         = j_r;
    lim_nxt       = lim_r;
    hole_nxt      = hole_r;
    s_nxt         = s_r;
    idx_nxt       = idx_r;
    cap_nxt       = cap_r;
    v_nxt         = v_r;
    total_nxt     = total_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_total_nxt = out_total_r;
    out_drop_nxt  = out_drop_r;
    mem_we        = 1'b0;
    mem_wsel      = sel_r;
    waddr         = '0;
    wdata         = '0;
    raddr_a       = '0;
    raddr_b       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_command)
            CMD_LOAD_ITEM: begin
              if (ni_r == CW'(MAX_ITEMS)) begin
                drop_nxt = 1'b1;
              end else begin
                mem_we   = 1'b1;
                mem_wsel = SEL_ITEM;
                waddr    = XW'(ni_r);
                wdata    = {in_item_weight, in_item_value};
                ni_nxt   = ni_r + CW'(1);
              end
            end
            CMD_LOAD_SLOT: begin
              if (ns_r == CW'(MAX_SLOTS)) begin
                drop_nxt = 1'b1;
              end else begin
                mem_we   = 1'b1;
                mem_wsel = SEL_SLOT;
                waddr    = XW'(ns_r);
                wdata    = KEY_W'(in_slot_capacity);
                ns_nxt   = ns_r + CW'(1);
              end
            end
            CMD_RUN: begin
              sel_nxt   = SEL_ITEM;
              state_nxt = ST_SORT;
            end
            default: ;
          endcase
        end
      end

      // Start heapsort of the selected set, or skip it when trivially sorted.
      ST_SORT: begin
        if (n_sort >= CW'(2)) begin
          j_nxt     = n_sort >> 1;
          state_nxt = ST_BLD_RD;
        end else if (sel_r == SEL_ITEM) begin
          sel_nxt   = SEL_SLOT;
        end else begin
          sel_nxt   = SEL_HEAP;
          s_nxt     = '0;
          idx_nxt   = '0;
          hs_nxt    = '0;
          total_nxt = '0;
          state_nxt = ST_M_SLOT;
        end
      end

      ST_BLD_RD: begin
        raddr_a   = XW'(j_r - CW'(1));
        state_nxt = ST_BLD_GO;
      end

      ST_BLD_GO: begin
        v_nxt     = key_a;
        hole_nxt  = j_r - CW'(1);
        lim_nxt   = n_sort;
        ret_nxt   = RET_BLD;
        state_nxt = ST_SIFT_RD;
      end

      ST_EXT_RD: begin
        raddr_a   = '0;
        raddr_b   = XW'(j_r);
        state_nxt = ST_EXT_GO;
      end

      // Park the current maximum at the end, sift the former last entry down.
      ST_EXT_GO: begin
        mem_we    = 1'b1;
        waddr     = XW'(j_r);
        wdata     = key_a;
        v_nxt     = key_b;
        hole_nxt  = '0;
        lim_nxt   = j_r;
        ret_nxt   = RET_EXT;
        state_nxt = ST_SIFT_RD;
      end

      ST_SIFT_RD: begin
        raddr_a   = lchild;
        raddr_b   = rchild;
        state_nxt = ST_SIFT_EV;
      end

      ST_SIFT_EV: begin
        mem_we = 1'b1;
        waddr  = XW'(hole_r);
        if (take) begin
          wdata     = big_key;
          hole_nxt  = big_idx[CW-1:0];
          state_nxt = ST_SIFT_RD;
        end else begin
          wdata     = v_r;
          state_nxt = ST_RET;
        end
      end

      ST_RET: begin
        case (ret_r)
          RET_BLD: begin
            if (j_r == CW'(1)) begin
              j_nxt = n_sort - CW'(1);
              state_nxt = ST_EXT_RD;
            end else begin
              j_nxt = j_r - CW'(1);
              state_nxt = ST_BLD_RD;
            end
          end
          RET_EXT: begin
            if (j_r != CW'(1)) begin
              j_nxt     = j_r - CW'(1);
              state_nxt = ST_EXT_RD;
            end else if (sel_r == SEL_ITEM) begin
              sel_nxt   = SEL_SLOT;
              state_nxt = ST_SORT;
            end else begin
              sel_nxt   = SEL_HEAP;
              s_nxt     = '0;
              idx_nxt   = '0;
              hs_nxt    = '0;
              total_nxt = '0;
              state_nxt = ST_M_SLOT;
            end
          end
          default: state_nxt = ST_M_SLOT;
        endcase
      end

      ST_M_SLOT: begin
        if (s_r == ns_r) begin
          state_nxt = ST_OUT;
        end else begin
          raddr_a   = XW'(s_r);
          state_nxt = ST_M_CAP;
        end
      end

      ST_M_CAP: begin
        cap_nxt   = slot_rd_a;
        state_nxt = ST_M_ITEM;
      end

      ST_M_ITEM: begin
        if (idx_r < ni_r) begin
          raddr_a   = XW'(idx_r);
          state_nxt = ST_M_CHK;
        end else begin
          state_nxt = ST_M_POP;
        end
      end

      // Push every item that fits the current capacity.
      ST_M_CHK: begin
        if (CAP_W'(item_rd_a[KEY_W-1:VAL_W]) <= cap_r) begin
          v_nxt     = KEY_W'(item_rd_a[VAL_W-1:0]);
          hole_nxt  = hs_r;
          hs_nxt    = hs_r + CW'(1);
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = ST_M_POP;
        end
      end

      ST_UP_RD: begin
        if (hole_r == '0) begin
          mem_we    = 1'b1;
          waddr     = '0;
          wdata     = v_r;
          state_nxt = ST_M_ITEM;
        end else begin
          raddr_a   = XW'(parent);
          state_nxt = ST_UP_EV;
        end
      end

      ST_UP_EV: begin
        mem_we = 1'b1;
        waddr  = XW'(hole_r);
        if (key_a < v_r) begin
          wdata     = key_a;
          hole_nxt  = parent;
          state_nxt = ST_UP_RD;
        end else begin
          wdata     = v_r;
          state_nxt = ST_M_ITEM;
        end
      end

      ST_M_POP: begin
        if (hs_r == '0) begin
          s_nxt     = s_r + CW'(1);
          state_nxt = ST_M_SLOT;
        end else begin
          raddr_a   = '0;
          raddr_b   = XW'(hs_r - CW'(1));
          state_nxt = ST_POP_GO;
        end
      end

      ST_POP_GO: begin
        total_nxt = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
        v_nxt     = key_b;
        hs_nxt    = hs_r - CW'(1);
        lim_nxt   = hs_r - CW'(1);
        hole_nxt  = '0;
        s_nxt     = s_r + CW'(1);
        ret_nxt   = RET_POP;
        state_nxt = ST_SIFT_RD;
      end

      ST_OUT: begin
        out_valid_nxt = 1'b1;
        out_total_nxt = total_r;
        out_drop_nxt  = drop_r;
        ni_nxt        = '0;
        ns_nxt        = '0;
        hs_nxt        = '0;
        drop_nxt      = 1'b0;
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ni_r        <= '0;
      ns_r        <= '0;
      hs_r        <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ni_r        <= ni_nxt;
      ns_r        <= ns_nxt;
      hs_r        <= hs_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    sel_r       <= sel_nxt;
    ret_r       <= ret_nxt;
    j_r         <= j_nxt;
    lim_r       <= lim_nxt;
    hole_r      <= hole_nxt;
    s_r         <= s_nxt;
    idx_r       <= idx_nxt;
    cap_r       <= cap_nxt;
    v_r         <= v_nxt;
    total_r     <= total_nxt;
    out_total_r <= out_total_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_total_value  = out_total_r;
  assign out_load_dropped = out_drop_r;

endmodule

// ===== rtl/cghma_checker.sv =====
// ---------------------------------------------------------------------------
// cghma_checker: port-level assertions for the greedy assigner
// Watches the handshakes and the run/result sequencing.
// ---------------------------------------------------------------------------
module cghma_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [cghma_pkg::CMD_W-1:0] in_command,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cghma_pkg::TOT_W-1:0] out_total_value,
  input logic                        out_load_dropped
);
  import cghma_pkg::*;

  // hold a pending result until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_value)
      && $stable(out_load_dropped))
    else $error("result dropped or changed while stalled");

  // never start a run over an untaken result
  a_run_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_RUN) |-> !out_valid || out_ready)
    else $error("run accepted while output busy");

  // a run blocks further input in the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_RUN) |=> !in_ready)
    else $error("input accepted during a run");

  // a result appears only at the end of a run
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a run");

endmodule

bind capacity_greedy_max_heap_assign_core cghma_checker u_cghma_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_command(in_command), .out_valid(out_valid), .out_ready(out_ready),
  .out_total_value(out_total_value), .out_load_dropped(out_load_dropped)
);
